// ----- hdl/cpsr_pkg.sv -----
// shared constants, types and the dlc length lookup for the can packet reassembler
// no dependencies
package cpsr_pkg;

  localparam int HEADER_BYTES      = 6;
  localparam int MAX_PAYLOAD_BYTES = 64;
  localparam int WORD_BYTES        = 8;
  localparam int ROWS              = (MAX_PAYLOAD_BYTES + WORD_BYTES - 1) / WORD_BYTES;
  localparam int ROW_W             = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W             = $clog2(HEADER_BYTES + MAX_PAYLOAD_BYTES + 1);
  localparam int PLEN_W            = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam int POS_W             = PLEN_W + 1;
  localparam int HDR_IDX_W         = $clog2(HEADER_BYTES);
  localparam int WORD_W            = 8 * WORD_BYTES;
  localparam int WIDX_W            = 3;
  localparam int IN_DATA_W         = 8;
  localparam int OUT_FIELDS_W      = 4 + 3 + 1 + 29 + 1 + 1 + 1 + 8 + WIDX_W + WORD_W;
  localparam int OUT_DATA_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic MODE_BYTE  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic byte_we;
    logic clear;
    logic rd;
  } cmd_t;

  typedef struct packed {
    logic pkt_done;
    logic last_word;
  } sts_t;

  function automatic logic [PLEN_W-1:0] dlc_len(input logic [3:0] dlc);
    logic [6:0] n;
    case (dlc)
      4'd9:    n = 7'd12;
      4'd10:   n = 7'd16;
      4'd11:   n = 7'd20;
      4'd12:   n = 7'd24;
      4'd13:   n = 7'd32;
      4'd14:   n = 7'd48;
      4'd15:   n = 7'd64;
      default: n = {3'd0, dlc};
    endcase
    if (32'(n) > MAX_PAYLOAD_BYTES) begin
      n = 7'(MAX_PAYLOAD_BYTES);
    end
    return PLEN_W'(n);
  endfunction

endpackage

// ----- hdl/cpsr_ctrl.sv -----
// controller for the can packet reassembler: collect and emit states, output valid
// depends on cpsr_pkg
module cpsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tuser,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output cpsr_pkg::cmd_t cmd,
  input  cpsr_pkg::sts_t sts
);
  import cpsr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   can_issue;

  assign accept    = in_tvalid && in_tready;
  assign can_issue = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_COLLECT: begin
        if (accept && in_tuser == MODE_BYTE && sts.pkt_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_issue && sts.last_word) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.byte_we = 1'b0;
    cmd.clear   = 1'b0;
    cmd.rd      = 1'b0;
    case (state_r)
      ST_COLLECT: begin
        in_tready   = 1'b1;
        cmd.byte_we = in_tvalid && in_tuser == MODE_BYTE;
        cmd.clear   = in_tvalid && in_tuser == MODE_CLEAR;
      end
      ST_EMIT: begin
        cmd.rd = can_issue;
      end
      default: ;
    endcase
    out_valid_nxt = cmd.rd ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ----- hdl/cpsr_datapath.sv -----
// datapath for the can packet reassembler: byte counter, header bytes,
// payload row memory and output registers; depends on cpsr_pkg
module cpsr_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cpsr_pkg::IN_DATA_W-1:0] in_tdata,
  input  cpsr_pkg::cmd_t                 cmd,
  output cpsr_pkg::sts_t                 sts,
  output logic [cpsr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import cpsr_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PLEN_W-1:0] plen_r, plen_cur;
  logic [ROW_W-1:0]  k_r;
  logic [7:0]        hdr_r [HEADER_BYTES];
  logic [WORD_W-1:0] mem [ROWS];

  logic [CNT_W-1:0]  pos;
  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  next_base;
  logic [7:0]        lane_mask;
  logic [31:0]       hw;

  logic [WORD_W-1:0] rd_data_r;
  logic [7:0]        mask_r;
  logic [3:0]        lc_r;
  logic [2:0]        bus_r;
  logic              fd_r;
  logic [28:0]       id_r;
  logic              ext_r;
  logic              ret_r;
  logic              rej_r;
  logic [7:0]        chk_r;
  logic [WIDX_W-1:0] widx_r;
  logic              last_r;
  logic [WORD_W-1:0] masked;

  assign plen_cur     = (cnt_r == '0) ? dlc_len(in_tdata[7:4]) : plen_r;
  assign sts.pkt_done = (32'(cnt_r) + 1) >= (HEADER_BYTES + 32'(plen_cur));
  assign pos          = cnt_r - CNT_W'(HEADER_BYTES);

  assign base         = POS_W'({k_r, 3'b000});
  assign next_base    = base + POS_W'(WORD_BYTES);
  assign sts.last_word = next_base >= POS_W'(plen_r);

  always_comb begin
    for (int b = 0; b < WORD_BYTES; b++) begin
      lane_mask[b] = (base + POS_W'(b)) < POS_W'(plen_r);
    end
  end

  assign hw = {hdr_r[4], hdr_r[3], hdr_r[2], hdr_r[1]};

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clear) begin
      cnt_nxt = '0;
    end else if (cmd.byte_we) begin
      cnt_nxt = sts.pkt_done ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      plen_r <= '0;
      k_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (cmd.byte_we && cnt_r == '0) begin
        plen_r <= plen_cur;
      end
      if (cmd.rd) begin
        k_r <= sts.last_word ? '0 : k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_we && 32'(cnt_r) < HEADER_BYTES) begin
      hdr_r[cnt_r[HDR_IDX_W-1:0]] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_we && 32'(cnt_r) >= HEADER_BYTES) begin
      mem[pos[3 +: ROW_W]][8 * pos[2:0] +: 8] <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[k_r];
      mask_r    <= lane_mask;
      lc_r      <= hdr_r[0][7:4];
      bus_r     <= hdr_r[0][3:1];
      fd_r      <= hdr_r[0][0];
      id_r      <= hw[31:3];
      ext_r     <= hw[2];
      ret_r     <= hw[1];
      rej_r     <= hw[0];
      chk_r     <= hdr_r[5];
      widx_r    <= WIDX_W'(k_r);
      last_r    <= sts.last_word;
    end
  end

  always_comb begin
    for (int b = 0; b < WORD_BYTES; b++) begin
      masked[8*b +: 8] = mask_r[b] ? rd_data_r[8*b +: 8] : 8'd0;
    end
  end

  assign out_tdata = {(OUT_DATA_W - OUT_FIELDS_W)'(0), masked, widx_r, chk_r,
                      rej_r, ret_r, ext_r, id_r, fd_r, bus_r, lc_r};
  assign out_tlast = last_r;

endmodule

// ----- hdl/can_packet_stream_reassembler.sv -----
// top level of the can packet reassembler: controller plus datapath
// depends on cpsr_pkg, cpsr_ctrl, cpsr_datapath
//
// usage
//   input channel: one item per stream byte; in_tuser = 0 carries in_tdata as the
//   next byte of the host stream, in_tuser = 1 drops a partly collected packet.
//   each packet is a 6-byte header and a payload of 0..64 bytes set by the dlc.
//   output channel: one item per 8-byte payload word (at least one per packet),
//   header fields repeated on every word, out_tlast on the final word.
//   throughput: one byte per cycle while a packet is collected. after the final byte the
//   emit state reads the first word into the output register, then words follow one per
//   cycle while the receiver takes them, one row read of the payload memory each;
//   in_tready stays low for the whole emission, including while the output stalls.
//   a packet's last word may wait in the output register while the next packet
//   is already collected.
//   reset clears the byte counter and output valid; no clearing pass is needed.
//   when the receiver stalls, the word held stays stable and emission pauses.
module can_packet_stream_reassembler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cpsr_pkg::IN_DATA_W-1:0]  in_tdata,   // stream_byte
  input  logic                            in_tuser,   // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // length_code, bus_sel, fd_flag, identifier, extended_flag, returned_flag,
  // rejected_flag, check_byte, word_index, payload_word, zero fill
  output logic [cpsr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast  // last_word
);
  import cpsr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cpsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  cpsr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// ----- hdl/cpsr_checker.sv -----
// port-level checks for the can packet reassembler, bound to the top level
// depends on cpsr_pkg and can_packet_stream_reassembler
module cpsr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cpsr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import cpsr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output item changed while stalled");

  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && out_tdata[50:48] == $past(out_tdata[50:48]) + 3'd1)
    else $error("payload words not back to back in order");

  a_no_input_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input taken while packet words remain");

  a_empty_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:0] == 4'd0 |-> out_tdata[114:51] == '0 && out_tlast)
    else $error("empty packet word not zero or not last");

endmodule

bind can_packet_stream_reassembler cpsr_checker u_cpsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// testbench for can_packet_stream_reassembler: byte stream in, payload words out
// predicts every word from its own packet model and checks each field in order
// depends on cpsr_pkg and the reassembler rtl
module tb;
  import cpsr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic       mode;
    logic [7:0] data;
  } stream_item_t;

  typedef struct {
    logic [3:0]  length_code;
    logic [2:0]  bus_sel;
    logic        fd_flag;
    logic [28:0] identifier;
    logic        extended_flag;
    logic        returned_flag;
    logic        rejected_flag;
    logic [7:0]  check_byte;
    logic [2:0]  word_index;
    logic [63:0] payload_word;
    logic        last_word;
  } can_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  stream_item_t stream_q[$];
  can_word_t    word_q[$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           items_queued = 0;
  int           items_taken = 0;
  logic         in_fire = 1'b0;

  // packet model state
  int unsigned dlc_bytes [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 12, 16, 20, 24, 32, 48, 64};
  logic [7:0]  hdr_bytes [HEADER_BYTES];
  logic [7:0]  pay_bytes [MAX_PAYLOAD_BYTES];
  int unsigned bytes_got = 0;
  int unsigned pkt_total = 0;

  // sender and receiver pacing
  int tx_burst = 1;
  int tx_gap = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  can_word_t got_w;
  can_word_t exp_w;

  can_packet_stream_reassembler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic absorb_item(input logic mode, input logic [7:0] data);
    int unsigned plen;
    int unsigned nwords;
    int unsigned idx;
    logic [31:0] hw;
    can_word_t   w;
    if (mode == MODE_CLEAR) begin
      bytes_got = 0;
      pkt_total = 0;
    end else begin
      if (bytes_got == 0) begin
        plen = dlc_bytes[data[7:4]];
        if (plen > MAX_PAYLOAD_BYTES) plen = MAX_PAYLOAD_BYTES;
        pkt_total = HEADER_BYTES + plen;
      end
      if (bytes_got < HEADER_BYTES) begin
        hdr_bytes[bytes_got] = data;
      end else if (bytes_got - HEADER_BYTES < MAX_PAYLOAD_BYTES) begin
        pay_bytes[bytes_got - HEADER_BYTES] = data;
      end
      bytes_got++;
      if (bytes_got >= pkt_total) begin
        plen = pkt_total - HEADER_BYTES;
        nwords = (plen + 7) / 8;
        if (nwords == 0) nwords = 1;
        hw = {hdr_bytes[4], hdr_bytes[3], hdr_bytes[2], hdr_bytes[1]};
        for (int k = 0; k < nwords; k++) begin
          w.length_code   = hdr_bytes[0][7:4];
          w.bus_sel       = hdr_bytes[0][3:1];
          w.fd_flag       = hdr_bytes[0][0];
          w.identifier    = hw[31:3];
          w.extended_flag = hw[2];
          w.returned_flag = hw[1];
          w.rejected_flag = hw[0];
          w.check_byte    = hdr_bytes[5];
          w.word_index    = 3'(k);
          w.payload_word  = '0;
          for (int b = 0; b < 8; b++) begin
            idx = k * 8 + b;
            if (idx < plen && idx < MAX_PAYLOAD_BYTES) w.payload_word[8*b +: 8] = pay_bytes[idx];
          end
          w.last_word = (k + 1 == nwords);
          word_q.push_back(w);
        end
        for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) pay_bytes[i] = 8'h00;
        bytes_got = 0;
        pkt_total = 0;
      end
    end
  endtask

  task automatic push_item(input logic mode, input logic [7:0] data);
    stream_item_t it;
    it.mode = mode;
    it.data = data;
    stream_q.push_back(it);
    items_queued++;
  endtask

  // whole packet when keep covers it, else the first keep bytes and a clear
  task automatic push_packet(input logic [3:0] dlc, input int keep);
    int total;
    total = HEADER_BYTES + dlc_bytes[dlc];
    if (total > HEADER_BYTES + MAX_PAYLOAD_BYTES) total = HEADER_BYTES + MAX_PAYLOAD_BYTES;
    for (int i = 0; i < total && i < keep; i++) begin
      if (i == 0) push_item(MODE_BYTE, {dlc, 4'($urandom_range(0, 15))});
      else push_item(MODE_BYTE, 8'($urandom_range(0, 255)));
    end
    if (keep < total) push_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_random(input int count);
    int start;
    int r;
    int total;
    logic [3:0] dlc;
    start = items_queued;
    while (items_queued - start < count) begin
      r = $urandom_range(0, 99);
      dlc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      total = HEADER_BYTES + dlc_bytes[dlc];
      if (r < 6) push_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
      else if (r < 14) push_packet(dlc, $urandom_range(1, total - 1));
      else push_packet(dlc, total);
    end
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (items_taken != items_queued || word_q.size() != 0);
  endtask

  task automatic field_check(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      fail_count++;
    end
  endtask

  // driver
  always @(negedge clk) begin
    stream_item_t it;
    logic         next_valid;
    next_valid = in_tvalid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_tvalid || in_fire) begin
      next_valid = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
      end else if (stream_q.size() > 0) begin
        it = stream_q.pop_front();
        in_tdata <= it.data;
        in_tuser <= it.mode;
        next_valid = 1'b1;
        tx_burst--;
        if (tx_burst <= 0) begin
          tx_burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 24);
          tx_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
      end
    end
    in_tvalid <= next_valid;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(50, 300);
    end
    rx_left--;
    rx_tick++;
    if (!rst_n) out_tready <= 1'b0;
    else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= (rx_tick % 5 == 0);
        default: out_tready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      absorb_item(in_tuser, in_tdata);
      items_taken++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_w.length_code   = out_tdata[3:0];
      got_w.bus_sel       = out_tdata[6:4];
      got_w.fd_flag       = out_tdata[7];
      got_w.identifier    = out_tdata[36:8];
      got_w.extended_flag = out_tdata[37];
      got_w.returned_flag = out_tdata[38];
      got_w.rejected_flag = out_tdata[39];
      got_w.check_byte    = out_tdata[47:40];
      got_w.word_index    = out_tdata[50:48];
      got_w.payload_word  = out_tdata[114:51];
      got_w.last_word     = out_tlast;
      if (word_q.size() == 0) begin
        $display("%0t: unexpected item, expected none actual index %0d payload %0h",
                 $time, got_w.word_index, got_w.payload_word);
        fail_count++;
      end else begin
        exp_w = word_q.pop_front();
        field_check("length_code", 64'(exp_w.length_code), 64'(got_w.length_code));
        field_check("bus_sel", 64'(exp_w.bus_sel), 64'(got_w.bus_sel));
        field_check("fd_flag", 64'(exp_w.fd_flag), 64'(got_w.fd_flag));
        field_check("identifier", 64'(exp_w.identifier), 64'(got_w.identifier));
        field_check("extended_flag", 64'(exp_w.extended_flag), 64'(got_w.extended_flag));
        field_check("returned_flag", 64'(exp_w.returned_flag), 64'(got_w.returned_flag));
        field_check("rejected_flag", 64'(exp_w.rejected_flag), 64'(got_w.rejected_flag));
        field_check("check_byte", 64'(exp_w.check_byte), 64'(got_w.check_byte));
        field_check("word_index", 64'(exp_w.word_index), 64'(got_w.word_index));
        field_check("payload_word", exp_w.payload_word, got_w.payload_word);
        field_check("last_word", 64'(exp_w.last_word), 64'(got_w.last_word));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items pending", $time, word_q.size());
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) pay_bytes[i] = 8'h00;
    for (int i = 0; i < HEADER_BYTES; i++) hdr_bytes[i] = 8'h00;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // clear with nothing collected
    push_item(MODE_CLEAR, 8'hff);
    // empty payload, all header bits set
    push_item(MODE_BYTE, 8'h0f);
    repeat (5) push_item(MODE_BYTE, 8'hff);
    // partial packet dropped by a clear
    push_item(MODE_BYTE, 8'h80);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_CLEAR, 8'h00);
    // one payload byte, header bits clear
    push_item(MODE_BYTE, 8'h10);
    repeat (5) push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'hff);
    // mixed header pattern, two payload bytes
    push_item(MODE_BYTE, 8'h2a);
    push_item(MODE_BYTE, 8'h5a);
    push_item(MODE_BYTE, 8'ha5);
    push_item(MODE_BYTE, 8'h3c);
    push_item(MODE_BYTE, 8'hc3);
    push_item(MODE_BYTE, 8'h81);
    push_item(MODE_BYTE, 8'h00);
    push_item(MODE_BYTE, 8'h80);

    push_random(250);
    // sender holds off until every expected item is out
    wait_drained();
    push_random(250);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (word_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, word_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
